FILE: src/tbp_pkg.sv
// Shared types, constants and helper functions of the TAGE branch predictor.
// Used by tbp_mixer and tage_branch_predictor_top; depends on nothing else.
`default_nettype none
package tbp_pkg;

    localparam int PC_W       = 64;
    localparam int NUM_TBL    = 5;
    localparam int TBL_W      = 3;
    localparam int IDX_W      = 8;
    localparam int TAG_W      = 10;
    localparam int CTR_W      = 3;
    localparam int USE_W      = 2;
    localparam int TAG_DEPTH  = 1280;
    localparam int TAG_AW     = 11;
    localparam int BASE_DEPTH = 2048;
    localparam int BASE_AW    = 11;
    localparam int HIST_W     = 64;
    localparam int CNT_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_ALT_ON_WEAK  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AGING_PERIOD = 2'd1;

    localparam logic CMD_PREDICT = 1'b0;
    localparam logic CMD_TRAIN   = 1'b1;

    localparam logic [63:0] MIX_K1 = 64'hff51afd7ed558ccd;
    localparam logic [63:0] MIX_K2 = 64'hc4ceb9fe1a85ec53;
    localparam logic [63:0] GOLDEN = 64'h9e3779b97f4a7c15;

    localparam logic [CNT_W-1:0] AGING_RESET = 16'd16384;

    localparam int HIST_LENS  [NUM_TBL] = '{4, 8, 16, 32, 64};
    localparam int TAG_WIDTHS [NUM_TBL] = '{7, 7, 8, 9, 10};
    localparam logic [TAG_W-1:0] TAG_MASKS [NUM_TBL] =
        '{10'h07f, 10'h07f, 10'h0ff, 10'h1ff, 10'h3ff};

    typedef struct packed {
        logic [TAG_W-1:0]        tag;
        logic signed [CTR_W-1:0] ctr;
        logic [USE_W-1:0]        use_cnt;
    } t_entry;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_MIXI_GO,
        S_MIXI_WAIT,
        S_MIXT_GO,
        S_MIXT_WAIT,
        S_LK_RD,
        S_LK_CHK,
        S_LK_FIN,
        S_TRAIN,
        S_TR_PRD,
        S_TR_PWR,
        S_TR_ARD,
        S_TR_AWR,
        S_TR_BWR,
        S_AL_START,
        S_AL_RD,
        S_AL_TST,
        S_DC_RD,
        S_DC_WR,
        S_HIST,
        S_AGE,
        S_AGE_END,
        S_OUT
    } t_state;

    // XOR-folds the newest len history bits into width bit positions.
    function automatic logic [TAG_W-1:0] fold(input logic [HIST_W-1:0] h,
                                              input int len, input int width);
        logic [TAG_W-1:0] acc;
        int j;
        acc = '0;
        j = 0;
        for (int i = 0; i < HIST_W; i++) begin
            if (i < len) acc[j] = acc[j] ^ h[i];
            if (j == width - 1) j = 0;
            else j = j + 1;
        end
        return acc;
    endfunction

    function automatic logic [CTR_W-1:0] tagged_step(input logic [CTR_W-1:0] v,
                                                     input logic up);
        logic [CTR_W-1:0] r;
        if (up) r = (v == 3'b011) ? v : v + 3'd1;
        else    r = (v == 3'b100) ? v : v - 3'd1;
        return r;
    endfunction

    function automatic logic [1:0] base_step(input logic [1:0] v, input logic up);
        logic [1:0] r;
        if (up) r = (v == 2'b01) ? v : v + 2'd1;
        else    r = (v == 2'b10) ? v : v - 2'd1;
        return r;
    endfunction

    function automatic logic tagged_weak(input logic [CTR_W-1:0] v);
        return (v[2:1] == 2'b00) || (v == 3'b111);
    endfunction

    function automatic logic base_weak(input logic [1:0] v);
        return v != 2'b10;
    endfunction

endpackage
`default_nettype wire

FILE: src/tbp_mixer.sv
// 64-bit multiply mixer (xor-shift, multiply, xor-shift, multiply, xor-shift).
// Each 64x64 product is built from three 32x32 partial products, one per cycle.
// Depends on tbp_pkg.
`default_nettype none
module tbp_mixer (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic [tbp_pkg::PC_W-1:0] i_x,
    output logic                         o_done,
    output logic [tbp_pkg::PC_W-1:0]     o_y
);
    import tbp_pkg::*;

    logic            r_busy;
    logic            r_done;
    logic [1:0]      r_step;
    logic            r_pass;
    logic [63:0]     r_x;
    logic [63:0]     r_lo;
    logic [31:0]     r_c1;
    logic [31:0]     r_c2;

    logic [63:0] k_sel;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] prod;
    logic [63:0] sum;
    logic [63:0] shifted;

    always_comb begin
        k_sel   = r_pass ? MIX_K2 : MIX_K1;
        mul_a   = (r_step == 2'd1) ? r_x[63:32] : r_x[31:0];
        mul_b   = (r_step == 2'd2) ? k_sel[63:32] : k_sel[31:0];
        prod    = {32'd0, mul_a} * {32'd0, mul_b};
        // Only the low 32 bits of the cross terms reach the low 64 bits of the product.
        sum     = r_lo + {r_c1 + r_c2, 32'd0};
        shifted = sum ^ (sum >> 33);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= 2'd0;
            r_pass <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_x    <= i_x ^ (i_x >> 33);
                r_step <= 2'd0;
                r_pass <= 1'b0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                case (r_step)
                    2'd0: begin
                        r_lo   <= prod;
                        r_step <= 2'd1;
                    end
                    2'd1: begin
                        r_c1   <= prod[31:0];
                        r_step <= 2'd2;
                    end
                    2'd2: begin
                        r_c2   <= prod[31:0];
                        r_step <= 2'd3;
                    end
                    default: begin
                        r_x    <= shifted;
                        r_step <= 2'd0;
                        if (r_pass) begin
                            r_busy <= 1'b0;
                            r_done <= 1'b1;
                        end else begin
                            r_pass <= 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    assign o_done = r_done;
    assign o_y    = r_x;

endmodule
`default_nettype wire

FILE: src/tage_branch_predictor_top.sv
// TAGE branch direction predictor: bimodal base table plus five tagged tables.
// Depends on tbp_pkg and tbp_mixer.
//
// Usage: an input beat carries command, pc and taken; every input beat yields
// exactly one output beat with prediction, high_confidence and the alternate flag.
// o_in_stall is low only while the block is idle, so one item is in work at a
// time. A fresh lookup runs ten mixer invocations (two per tagged table) on one
// shared 32x32 multiplier, then reads the five tagged entries one by one. A train
// that reuses the stored lookup goes straight to the read-modify-write sequence
// on the tagged-entry memory; a train that needs a fresh lookup runs it first.
// When the aging count expires, a sweep over all 1280 tagged entries runs before
// the result is given. After reset a clearing pass over all 2048 base-table
// addresses zeroes both memories; input is stalled meanwhile, configuration
// writes are taken at any time.
// The result sits in an output register; if the receiver stalls, the block
// still accepts the next input beat and holds its next result until the
// previous one is taken.
`default_nettype none
module tage_branch_predictor_top (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic                           i_command,
    input  wire logic [tbp_pkg::PC_W-1:0]       i_pc,
    input  wire logic                           i_taken,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic                                o_prediction,
    output logic                                o_high_confidence,
    output logic                                o_alt_chosen,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [tbp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [tbp_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import tbp_pkg::*;

    t_state r_state;
    t_state n_state;

    logic                 r_alt_en;
    logic [CNT_W-1:0]     r_period;

    logic                 r_cmd;
    logic [PC_W-1:0]      r_pc;
    logic                 r_taken;
    logic [HIST_W-1:0]    r_hist;
    logic [CNT_W-1:0]     r_cnt;
    logic [TBL_W-1:0]     r_tbl;
    logic [TBL_W-1:0]     r_start;
    logic [PC_W-1:0]      r_addend;
    logic [BASE_AW-1:0]   r_clr;
    logic [TAG_AW-1:0]    r_sweep;
    logic [TAG_AW-1:0]    r_age_addr;
    logic                 r_age_vld;
    logic                 r_conf;

    logic                 r_lk_valid;
    logic [PC_W-1:0]      r_lk_pc;
    logic                 r_lk_phit;
    logic                 r_lk_ahit;
    logic [TBL_W-1:0]     r_lk_pbank;
    logic [TBL_W-1:0]     r_lk_abank;
    logic [CTR_W-1:0]     r_lk_pctr;
    logic [CTR_W-1:0]     r_lk_actr;
    logic                 r_lk_ppred;
    logic                 r_lk_apred;
    logic                 r_lk_pweak;
    logic                 r_lk_used_alt;
    logic                 r_lk_final;
    logic [IDX_W-1:0]     r_lk_idx [NUM_TBL];
    logic [TAG_W-1:0]     r_lk_tag [NUM_TBL];

    logic                 r_out_valid;
    logic                 r_out_pred;
    logic                 r_out_conf;
    logic                 r_out_alt;

    logic [1:0]           r_base_mem [BASE_DEPTH];
    logic [1:0]           r_base_q;
    t_entry               r_tag_mem [TAG_DEPTH];
    t_entry               r_tag_q;

    logic                 mix_start;
    logic [PC_W-1:0]      mix_x;
    logic                 mix_done;
    logic [PC_W-1:0]      mix_y;

    logic [TAG_W-1:0]     fold_idx [NUM_TBL];
    logic [TAG_W-1:0]     fold_tag [NUM_TBL];

    logic [IDX_W-1:0]     idx_sel;
    logic [TAG_W-1:0]     tag_sel;
    logic [TAG_AW-1:0]    tag_raddr;
    logic                 tag_we;
    logic [TAG_AW-1:0]    tag_waddr;
    t_entry               tag_wdata;
    logic                 base_we;
    logic [BASE_AW-1:0]   base_waddr;
    logic [1:0]           base_wdata;

    logic                 in_accept;
    logic                 need_lookup;
    logic                 pc_ok;
    logic                 ac_ok;
    logic [TBL_W-1:0]     alloc_start;
    logic [CNT_W-1:0]     cnt_inc;
    logic                 age_now;
    logic                 out_load;
    logic [CTR_W-1:0]     p_ctr_new;
    logic [USE_W-1:0]     p_use_new;
    logic [1:0]           b_new;
    logic                 lk_bpred;
    logic                 lk_apred;
    logic                 lk_ppred;
    logic                 lk_pweak;
    logic                 lk_used;

    tbp_mixer u_mixer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mix_start),
        .i_x     (mix_x),
        .o_done  (mix_done),
        .o_y     (mix_y)
    );

    for (genvar g = 0; g < NUM_TBL; g++) begin : g_fold
        localparam int HALF_LEN = HIST_LENS[g] / 2 + 1;
        assign fold_idx[g] = fold(r_hist, HIST_LENS[g], IDX_W);
        assign fold_tag[g] = fold(r_hist, HIST_LENS[g], TAG_WIDTHS[g])
                           ^ fold(r_hist, HALF_LEN, TAG_WIDTHS[g] - 1);
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_accept   = i_in_valid && !o_in_stall;

    always_comb begin
        idx_sel     = r_lk_idx[r_tbl];
        tag_sel     = r_lk_tag[r_tbl];
        need_lookup = (i_command == CMD_PREDICT) || !r_lk_valid || (i_pc != r_lk_pc);
        pc_ok       = (r_lk_ppred == r_taken);
        ac_ok       = (r_lk_apred == r_taken);
        alloc_start = r_lk_phit ? r_lk_pbank + 3'd1 : 3'd0;
        cnt_inc     = r_cnt + 16'd1;
        age_now     = (r_period != '0) && (cnt_inc >= r_period);
        out_load    = (r_state == S_OUT) && (!r_out_valid || !i_out_stall);

        p_ctr_new = tagged_step(r_tag_q.ctr, r_taken);
        p_use_new = r_tag_q.use_cnt;
        if (pc_ok != ac_ok) begin
            if (pc_ok) begin
                if (r_tag_q.use_cnt != 2'd3) p_use_new = r_tag_q.use_cnt + 2'd1;
            end else if (r_tag_q.use_cnt != 2'd0) begin
                p_use_new = r_tag_q.use_cnt - 2'd1;
            end
        end
        b_new = base_step(r_base_q, r_taken);

        lk_bpred = !r_base_q[1];
        lk_apred = r_lk_ahit ? !r_lk_actr[CTR_W-1] : lk_bpred;
        lk_ppred = r_lk_phit ? !r_lk_pctr[CTR_W-1] : lk_bpred;
        lk_pweak = r_lk_phit ? tagged_weak(r_lk_pctr) : base_weak(r_base_q);
        lk_used  = r_lk_phit && r_alt_en && lk_pweak && r_lk_ahit;
    end

    // Next state and memory / mixer controls.
    always_comb begin
        n_state    = r_state;
        mix_start  = 1'b0;
        mix_x      = r_pc + r_addend;
        tag_raddr  = {r_tbl, idx_sel};
        tag_we     = 1'b0;
        tag_waddr  = {r_tbl, idx_sel};
        tag_wdata  = r_tag_q;
        base_we    = 1'b0;
        base_waddr = r_pc[BASE_AW+1:2];
        base_wdata = b_new;
        case (r_state)
            S_CLEAR: begin
                base_we    = 1'b1;
                base_waddr = r_clr;
                base_wdata = 2'b00;
                tag_we     = (r_clr < TAG_AW'(TAG_DEPTH));
                tag_waddr  = TAG_AW'(r_clr);
                tag_wdata  = '0;
                if (r_clr == BASE_AW'(BASE_DEPTH - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (in_accept) n_state = need_lookup ? S_MIXI_GO : S_TRAIN;
            end
            S_MIXI_GO: begin
                mix_start = 1'b1;
                n_state   = S_MIXI_WAIT;
            end
            S_MIXI_WAIT: begin
                if (mix_done) n_state = S_MIXT_GO;
            end
            S_MIXT_GO: begin
                mix_start = 1'b1;
                mix_x     = r_pc ^ (PC_W'(r_tbl) + 64'd1);
                n_state   = S_MIXT_WAIT;
            end
            S_MIXT_WAIT: begin
                if (mix_done) begin
                    n_state = (r_tbl == TBL_W'(NUM_TBL - 1)) ? S_LK_RD : S_MIXI_GO;
                end
            end
            S_LK_RD:  n_state = S_LK_CHK;
            S_LK_CHK: n_state = (r_tbl == '0) ? S_LK_FIN : S_LK_RD;
            S_LK_FIN: n_state = (r_cmd == CMD_TRAIN) ? S_TRAIN : S_OUT;
            S_TRAIN:  n_state = r_lk_phit ? S_TR_PRD : S_TR_BWR;
            S_TR_PRD: n_state = S_TR_PWR;
            S_TR_PWR: begin
                tag_we    = 1'b1;
                tag_wdata = '{tag: r_tag_q.tag, ctr: p_ctr_new, use_cnt: p_use_new};
                if (r_lk_ahit && r_lk_pweak) n_state = S_TR_ARD;
                else if (!r_lk_ahit)         n_state = S_TR_BWR;
                else                         n_state = S_AL_START;
            end
            S_TR_ARD: n_state = S_TR_AWR;
            S_TR_AWR: begin
                tag_we    = 1'b1;
                tag_wdata = '{tag: r_tag_q.tag, ctr: p_ctr_new, use_cnt: r_tag_q.use_cnt};
                n_state   = S_AL_START;
            end
            S_TR_BWR: begin
                base_we = 1'b1;
                n_state = S_AL_START;
            end
            S_AL_START: begin
                if (r_lk_final == r_taken || alloc_start >= TBL_W'(NUM_TBL)) begin
                    n_state = S_HIST;
                end else begin
                    n_state = S_AL_RD;
                end
            end
            S_AL_RD: n_state = S_AL_TST;
            S_AL_TST: begin
                if (r_tag_q.use_cnt == '0) begin
                    tag_we    = 1'b1;
                    tag_wdata = '{tag: tag_sel, ctr: (r_taken ? 3'b000 : 3'b111),
                                  use_cnt: r_tag_q.use_cnt};
                    n_state   = S_HIST;
                end else if (r_tbl == TBL_W'(NUM_TBL - 1)) begin
                    n_state = S_DC_RD;
                end else begin
                    n_state = S_AL_RD;
                end
            end
            S_DC_RD: n_state = S_DC_WR;
            S_DC_WR: begin
                tag_we    = (r_tag_q.use_cnt != '0);
                tag_wdata = '{tag: r_tag_q.tag, ctr: r_tag_q.ctr,
                              use_cnt: r_tag_q.use_cnt - 2'd1};
                n_state   = (r_tbl == TBL_W'(NUM_TBL - 1)) ? S_HIST : S_DC_RD;
            end
            S_HIST: n_state = age_now ? S_AGE : S_OUT;
            S_AGE: begin
                tag_raddr = r_sweep;
                tag_we    = r_age_vld;
                tag_waddr = r_age_addr;
                tag_wdata = '{tag: r_tag_q.tag, ctr: r_tag_q.ctr,
                              use_cnt: r_tag_q.use_cnt >> 1};
                if (r_sweep == TAG_AW'(TAG_DEPTH - 1)) n_state = S_AGE_END;
            end
            S_AGE_END: begin
                tag_we    = 1'b1;
                tag_waddr = r_age_addr;
                tag_wdata = '{tag: r_tag_q.tag, ctr: r_tag_q.ctr,
                              use_cnt: r_tag_q.use_cnt >> 1};
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (out_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_CLEAR;
        else          r_state <= n_state;
    end

    // Both memories: one write port and one registered read port each.
    always_ff @(posedge i_clk) begin
        if (base_we) r_base_mem[base_waddr] <= base_wdata;
        r_base_q <= r_base_mem[r_pc[BASE_AW+1:2]];
    end

    always_ff @(posedge i_clk) begin
        if (tag_we) r_tag_mem[tag_waddr] <= tag_wdata;
        r_tag_q <= r_tag_mem[tag_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alt_en <= 1'b1;
            r_period <= AGING_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ALT_ON_WEAK:  r_alt_en <= i_cfg_data[0];
                CFG_AGING_PERIOD: r_period <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr         <= '0;
            r_hist        <= '0;
            r_cnt         <= '0;
            r_tbl         <= '0;
            r_age_vld     <= 1'b0;
            r_lk_valid    <= 1'b0;
            r_lk_pc       <= '0;
            r_lk_phit     <= 1'b0;
            r_lk_ahit     <= 1'b0;
            r_lk_pbank    <= '0;
            r_lk_abank    <= '0;
            r_lk_ppred    <= 1'b0;
            r_lk_apred    <= 1'b0;
            r_lk_pweak    <= 1'b0;
            r_lk_used_alt <= 1'b0;
            r_lk_final    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && !out_load) r_out_valid <= 1'b0;
            case (r_state)
                S_CLEAR: r_clr <= r_clr + 11'd1;
                S_IDLE: begin
                    if (in_accept) begin
                        r_cmd   <= i_command;
                        r_pc    <= i_pc;
                        r_taken <= i_taken;
                        if (need_lookup) begin
                            r_tbl      <= '0;
                            r_addend   <= '0;
                            r_lk_valid <= 1'b1;
                            r_lk_pc    <= i_pc;
                            r_lk_phit  <= 1'b0;
                            r_lk_ahit  <= 1'b0;
                            r_lk_pbank <= '0;
                            r_lk_abank <= '0;
                        end
                    end
                end
                S_MIXI_WAIT: begin
                    if (mix_done) begin
                        r_lk_idx[r_tbl] <= r_pc[IDX_W+1:2] ^ fold_idx[r_tbl][IDX_W-1:0]
                                         ^ mix_y[IDX_W-1:0];
                    end
                end
                S_MIXT_WAIT: begin
                    if (mix_done) begin
                        r_lk_tag[r_tbl] <= (r_pc[TAG_W+1:2] ^ fold_tag[r_tbl]
                                           ^ mix_y[TAG_W-1:0]) & TAG_MASKS[r_tbl];
                        if (r_tbl != TBL_W'(NUM_TBL - 1)) begin
                            r_tbl    <= r_tbl + 3'd1;
                            r_addend <= r_addend + GOLDEN;
                        end
                    end
                end
                S_LK_CHK: begin
                    // Scan from the longest history down: first hit provides,
                    // second hit is the alternate.
                    if (r_tag_q.tag == tag_sel) begin
                        if (!r_lk_phit) begin
                            r_lk_phit  <= 1'b1;
                            r_lk_pbank <= r_tbl;
                            r_lk_pctr  <= r_tag_q.ctr;
                        end else if (!r_lk_ahit) begin
                            r_lk_ahit  <= 1'b1;
                            r_lk_abank <= r_tbl;
                            r_lk_actr  <= r_tag_q.ctr;
                        end
                    end
                    if (r_tbl != '0) r_tbl <= r_tbl - 3'd1;
                end
                S_LK_FIN: begin
                    r_lk_ppred    <= lk_ppred;
                    r_lk_apred    <= lk_apred;
                    r_lk_pweak    <= lk_pweak;
                    r_lk_used_alt <= lk_used;
                    r_lk_final    <= lk_used ? lk_apred : lk_ppred;
                    r_conf        <= !lk_pweak;
                end
                S_TRAIN: r_tbl <= r_lk_pbank;
                S_TR_PWR: begin
                    r_conf <= !tagged_weak(p_ctr_new);
                    r_tbl  <= r_lk_abank;
                end
                S_TR_BWR: begin
                    if (!r_lk_phit) r_conf <= !base_weak(b_new);
                end
                S_AL_START: begin
                    r_tbl   <= alloc_start;
                    r_start <= alloc_start;
                end
                S_AL_TST: begin
                    if (r_tag_q.use_cnt != '0) begin
                        if (r_tbl == TBL_W'(NUM_TBL - 1)) r_tbl <= r_start;
                        else                              r_tbl <= r_tbl + 3'd1;
                    end
                end
                S_DC_WR: begin
                    if (r_tbl != TBL_W'(NUM_TBL - 1)) r_tbl <= r_tbl + 3'd1;
                end
                S_HIST: begin
                    r_hist    <= {r_hist[HIST_W-2:0], r_taken};
                    r_cnt     <= age_now ? '0 : cnt_inc;
                    r_sweep   <= '0;
                    r_age_vld <= 1'b0;
                end
                S_AGE: begin
                    r_age_addr <= r_sweep;
                    r_age_vld  <= 1'b1;
                    if (r_sweep != TAG_AW'(TAG_DEPTH - 1)) r_sweep <= r_sweep + 11'd1;
                end
                S_OUT: begin
                    if (out_load) begin
                        r_out_valid <= 1'b1;
                        r_out_pred  <= r_lk_final;
                        r_out_conf  <= r_conf;
                        r_out_alt   <= r_lk_valid && r_lk_used_alt;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_prediction      = r_out_pred;
    assign o_high_confidence = r_out_conf;
    assign o_alt_chosen      = r_out_alt;

endmodule
`default_nettype wire

FILE: test/testbench.sv
// Self-checking testbench for tage_branch_predictor_top: an in-bench TAGE model
// predicts each result, which is compared against the block's outputs.
// Depends on tbp_pkg and the block's RTL.
`default_nettype none
module testbench;
    import tbp_pkg::*;

    localparam int LIMIT_CYCLES = 1500000;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int MODE_NONE = 0, MODE_SEND = 1, MODE_RECV = 2, MODE_BOTH = 3;

    typedef struct {
        logic pred;
        logic conf;
        logic alt;
    } t_dir_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic i_command = CMD_PREDICT;
    logic [PC_W-1:0] i_pc = '0;
    logic i_taken = 1'b0;
    logic i_out_stall = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_ALT_ON_WEAK;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic o_in_stall, o_out_valid, o_prediction, o_high_confidence, o_alt_chosen;
    logic o_cfg_ready;

    tage_branch_predictor_top u_dut (.*);

    always #5 i_clk = ~i_clk;

    // Predictor state kept by the bench.
    int base_ctr [BASE_DEPTH];
    int ent_tag [NUM_TBL][256];
    int ent_ctr [NUM_TBL][256];
    int ent_use [NUM_TBL][256];
    logic [63:0] ghist;
    int upd_count;
    logic alt_en;
    int aging_len;
    logic [63:0] lk_pc;
    int lk_idx [NUM_TBL];
    int lk_tag [NUM_TBL];
    logic lk_valid, lk_phit, lk_ahit, lk_ppred, lk_apred, lk_pweak, lk_alt, lk_final;
    int lk_pbank, lk_abank;

    t_dir_result pending_dirs[$];
    int fails = 0;
    int cycles = 0;
    int idle_mode = MODE_NONE;
    logic [63:0] pc_pool [16];

    function automatic logic [63:0] mix64(input logic [63:0] v);
        logic [63:0] x;
        x = v;
        x = x ^ (x >> 33);
        x = x * MIX_K1;
        x = x ^ (x >> 33);
        x = x * MIX_K2;
        x = x ^ (x >> 33);
        return x;
    endfunction

    function automatic logic [63:0] hist_fold(input int len, input int width);
        logic [63:0] acc;
        acc = '0;
        for (int i = 0; i < len; i++)
            if (ghist[i]) acc[i % width] = ~acc[i % width];
        return acc & ((64'd1 << width) - 64'd1);
    endfunction

    function automatic int sat_step(input int v, input logic up, input int bits);
        int hi, lo;
        hi = (1 << (bits - 1)) - 1;
        lo = -(1 << (bits - 1));
        if (up) return (v >= hi) ? hi : v + 1;
        return (v <= lo) ? lo : v - 1;
    endfunction

    function automatic logic weak_ctr(input int v);
        return v >= -1 && v <= 1;
    endfunction

    function automatic int slot_of(input logic [63:0] pc);
        return int'((pc >> 2) & 64'(BASE_DEPTH - 1));
    endfunction

    task automatic tage_lookup(input logic [63:0] pc);
        logic [63:0] h, g;
        logic bim_dir;
        int tb, hl, c;
        bim_dir = base_ctr[slot_of(pc)] >= 0;
        lk_valid = 1'b1;
        lk_pc = pc;
        lk_phit = 1'b0; lk_ahit = 1'b0; lk_pbank = 0; lk_abank = 0;
        for (int t = 0; t < NUM_TBL; t++) begin
            tb = TAG_WIDTHS[t];
            hl = HIST_LENS[t];
            h = (pc >> 2) ^ hist_fold(hl, IDX_W) ^ mix64(pc + 64'(t) * GOLDEN);
            lk_idx[t] = int'(h[7:0]);
            g = (pc >> 2) ^ hist_fold(hl, tb) ^ hist_fold(hl / 2 + 1, tb - 1);
            g = g ^ mix64(pc ^ 64'(t + 1));
            lk_tag[t] = int'(g & ((64'd1 << tb) - 64'd1));
        end
        for (int b = NUM_TBL - 1; b >= 0; b--) begin
            if (ent_tag[b][lk_idx[b]] == lk_tag[b]) begin
                if (!lk_phit) begin
                    lk_phit = 1'b1;
                    lk_pbank = b;
                end else if (!lk_ahit) begin
                    lk_ahit = 1'b1;
                    lk_abank = b;
                end
            end
        end
        lk_apred = lk_ahit ? ent_ctr[lk_abank][lk_idx[lk_abank]] >= 0 : bim_dir;
        if (!lk_phit) begin
            lk_ppred = bim_dir;
            lk_pweak = weak_ctr(base_ctr[slot_of(pc)]);
            lk_alt = 1'b0;
            lk_final = bim_dir;
        end else begin
            c = ent_ctr[lk_pbank][lk_idx[lk_pbank]];
            lk_ppred = c >= 0;
            lk_pweak = weak_ctr(c);
            lk_alt = alt_en && lk_pweak && lk_ahit;
            lk_final = lk_alt ? lk_apred : lk_ppred;
        end
    endtask

    task automatic tage_allocate(input logic taken);
        int first;
        first = lk_phit ? lk_pbank + 1 : 0;
        for (int t = first; t < NUM_TBL; t++) begin
            if (ent_use[t][lk_idx[t]] == 0) begin
                ent_tag[t][lk_idx[t]] = lk_tag[t];
                ent_ctr[t][lk_idx[t]] = taken ? 0 : -1;
                return;
            end
        end
        for (int t = first; t < NUM_TBL; t++)
            if (ent_use[t][lk_idx[t]] > 0) ent_use[t][lk_idx[t]]--;
    endtask

    task automatic tage_train(input logic [63:0] pc, input logic taken);
        int bs, pb, ab;
        logic p_ok, a_ok;
        bs = slot_of(pc);
        if (!lk_valid || lk_pc != pc) tage_lookup(pc);
        p_ok = lk_ppred == taken;
        a_ok = lk_apred == taken;
        pb = lk_pbank;
        ab = lk_abank;
        if (lk_phit) begin
            ent_ctr[pb][lk_idx[pb]] = sat_step(ent_ctr[pb][lk_idx[pb]], taken, CTR_W);
            if (lk_ahit && lk_pweak)
                ent_ctr[ab][lk_idx[ab]] = sat_step(ent_ctr[ab][lk_idx[ab]], taken, CTR_W);
            else if (!lk_ahit)
                base_ctr[bs] = sat_step(base_ctr[bs], taken, 2);
            if (p_ok != a_ok) begin
                if (p_ok && ent_use[pb][lk_idx[pb]] < 3) ent_use[pb][lk_idx[pb]]++;
                else if (!p_ok && ent_use[pb][lk_idx[pb]] > 0) ent_use[pb][lk_idx[pb]]--;
            end
        end else begin
            base_ctr[bs] = sat_step(base_ctr[bs], taken, 2);
        end
        if (lk_final != taken) tage_allocate(taken);
        ghist = {ghist[62:0], taken};
        upd_count = (upd_count + 1) & 16'hffff;
        if (aging_len != 0 && upd_count >= aging_len) begin
            upd_count = 0;
            for (int t = 0; t < NUM_TBL; t++)
                for (int i = 0; i < 256; i++) ent_use[t][i] = ent_use[t][i] >> 1;
        end
    endtask

    task automatic tage_predict_step(input logic cmd, input logic [63:0] pc,
                                     input logic taken, output t_dir_result r);
        int c;
        if (cmd == CMD_TRAIN) tage_train(pc, taken);
        else tage_lookup(pc);
        c = lk_phit ? ent_ctr[lk_pbank][lk_idx[lk_pbank]] : base_ctr[slot_of(lk_pc)];
        r.pred = lk_final;
        r.conf = lk_valid && !weak_ctr(c);
        r.alt = lk_valid && lk_alt;
    endtask

    // Sender: holds the beat until accepted, then records the expected result.
    task automatic send_branch(input logic cmd, input logic [63:0] pc, input logic taken);
        int gap;
        t_dir_result r;
        gap = 0;
        if (idle_mode == MODE_SEND || idle_mode == MODE_BOTH)
            while ($urandom_range(99) < ((idle_mode == MODE_SEND) ? 57 : 10) && gap < 20)
                gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command <= cmd;
        i_pc <= pc;
        i_taken <= taken;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        tage_predict_step(cmd, pc, taken, r);
        pending_dirs.push_back(r);
        @(negedge i_clk);
    endtask

    task automatic wait_drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_dirs.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        wait_drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == CFG_ALT_ON_WEAK) alt_en = val[0];
        else if (idx == CFG_AGING_PERIOD) aging_len = val;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [63:0] pick_pc();
        if ($urandom_range(9) == 0) return {$urandom, $urandom};
        return pc_pool[$urandom_range(15)];
    endfunction

    task automatic test_directed();
        logic [63:0] ones;
        ones = '1;
        send_branch(CMD_TRAIN, 64'h0, 1'b1);          // train with no lookup yet
        send_branch(CMD_PREDICT, 64'h0, 1'b0);
        send_branch(CMD_PREDICT, ones, 1'b1);
        send_branch(CMD_TRAIN, ones, 1'b0);           // reuses stored lookup
        send_branch(CMD_TRAIN, 64'h4, 1'b0);          // different pc: fresh lookup
        for (int i = 0; i < 6; i++) begin
            send_branch(CMD_PREDICT, 64'h1000, 1'b0);
            send_branch(CMD_TRAIN, 64'h1000, i[0]);
        end
        for (int i = 0; i < 5; i++) send_branch(CMD_TRAIN, 64'h8000_0000_0000_0010, 1'b1);
        send_branch(CMD_PREDICT, 64'h5555_5555_5555_5555, 1'b1);
        send_branch(CMD_TRAIN, 64'haaaa_aaaa_aaaa_aaaa, 1'b0);
    endtask

    task automatic random_branches(input int count);
        logic [63:0] pc;
        logic taken;
        for (int n = 0; n < count; n++) begin
            pc = pick_pc();
            taken = ($urandom_range(9) < 8) ? pc[4] : $urandom_range(1);
            case ($urandom_range(9))
                0: send_branch(CMD_TRAIN, pc, taken);
                1: send_branch(CMD_PREDICT, pc, $urandom_range(1));
                default: begin
                    send_branch(CMD_PREDICT, pc, $urandom_range(1));
                    send_branch(CMD_TRAIN, pc, taken);
                    n++;
                end
            endcase
        end
    endtask

    task automatic test_alt_disabled();
        write_reg(CFG_ALT_ON_WEAK, 16'h0);
        random_branches(30);
        write_reg(CFG_ALT_ON_WEAK, 16'hfffe);       // upper bits masked: stays off
        random_branches(10);
        write_reg(CFG_ALT_ON_WEAK, 16'h1);
    endtask

    task automatic test_aging();
        write_reg(CFG_AGING_PERIOD, 16'd1);
        random_branches(8);
        write_reg(CFG_AGING_PERIOD, 16'd3);
        random_branches(16);
        write_reg(CFG_UNUSED, 16'hffff);
        write_reg(CFG_AGING_PERIOD, 16'd0);
        random_branches(20);
        write_reg(CFG_AGING_PERIOD, 16'hffff);
        random_branches(10);
    endtask

    task automatic test_random();
        for (int m = MODE_NONE; m <= MODE_BOTH; m++) begin
            idle_mode = m;
            random_branches(80);
        end
        idle_mode = MODE_NONE;
    endtask

    always @(negedge i_clk) begin
        case (idle_mode)
            MODE_RECV: i_out_stall <= $urandom_range(99) < 57;
            MODE_BOTH: i_out_stall <= $urandom_range(99) < 10;
            default:   i_out_stall <= 1'b0;
        endcase
    end

    always @(posedge i_clk) begin
        t_dir_result e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_dirs.size() == 0) begin
                $display("%0t: unexpected result pred=%b conf=%b alt=%b", $time,
                         o_prediction, o_high_confidence, o_alt_chosen);
                fails++;
            end else begin
                e = pending_dirs.pop_front();
                if (o_prediction !== e.pred || o_high_confidence !== e.conf ||
                    o_alt_chosen !== e.alt) begin
                    $display("%0t: expected pred=%b conf=%b alt=%b, got %b %b %b", $time,
                             e.pred, e.conf, e.alt, o_prediction, o_high_confidence,
                             o_alt_chosen);
                    fails++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("FAIL tage_branch_predictor_top");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < BASE_DEPTH; i++) base_ctr[i] = 0;
        for (int t = 0; t < NUM_TBL; t++)
            for (int i = 0; i < 256; i++) begin
                ent_tag[t][i] = 0;
                ent_ctr[t][i] = 0;
                ent_use[t][i] = 0;
            end
        for (int i = 0; i < 16; i++) pc_pool[i] = {$urandom, $urandom} & ~64'h3;
        pc_pool[0] = '0;
        pc_pool[1] = '1;
        ghist = '0;
        upd_count = 0;
        alt_en = 1'b1;
        aging_len = 16384;
        lk_pc = '0;
        lk_valid = 1'b0; lk_phit = 1'b0; lk_ahit = 1'b0; lk_ppred = 1'b0;
        lk_apred = 1'b0; lk_pweak = 1'b0; lk_alt = 1'b0; lk_final = 1'b0;
        lk_pbank = 0; lk_abank = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_alt_disabled();
        test_aging();
        test_random();
        wait_drain();
        repeat (200) @(negedge i_clk);
        if (fails == 0 && pending_dirs.size() == 0) begin
            $display("PASS tage_branch_predictor_top");
        end else begin
            $display("FAIL tage_branch_predictor_top");
        end
        $finish;
    end
endmodule
`default_nettype wire

FILE: files.f
src/tbp_pkg.sv
src/tbp_mixer.sv
src/tage_branch_predictor_top.sv
test/testbench.sv
